// ===== hw/rtl/cimd_pkg.sv =====
package cimd_pkg;

    localparam int unsigned BANK_W      = 32;
    localparam int unsigned IDX_W       = 6;
    localparam int unsigned BIT_W       = 5;
    localparam int unsigned CMD_W       = 3;
    localparam int unsigned CASCADE_BIT = 31;

    localparam logic [CMD_W-1:0] CMD_RAISE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UNMASK   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MASK     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ACK      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd4;

    localparam logic [BANK_W-1:0] CASCADE_MASK = BANK_W'(1) << CASCADE_BIT;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  irq_index;
        logic [BANK_W-1:0] sys_raise_bits;
        logic [BANK_W-1:0] per_raise_bits;
    } t_in_item;

    typedef struct packed {
        logic             irq_valid;
        logic [IDX_W-1:0] irq_number;
        logic             spurious;
        logic             spurious_bank;
    } t_out_item;

    typedef struct packed {
        logic [BANK_W-1:0] sys_status;
        logic [BANK_W-1:0] sys_mask;
        logic [BANK_W-1:0] per_status;
        logic [BANK_W-1:0] per_mask;
    } t_bank_state;

    // priority encode, lowest set bit; all-zero input gives the top index
    function automatic logic [BIT_W-1:0] lowest_set(input logic [BANK_W-1:0] v);
        logic [BIT_W-1:0] n;
        n = BIT_W'(BANK_W - 1);
        for (int i = BANK_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                n = BIT_W'(i);
            end
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/cimd_bank_regs.sv =====
module cimd_bank_regs
    import cimd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  t_in_item    i_item,
    output t_bank_state o_state
);

    t_bank_state r_state;
    t_bank_state n_state;

    logic [BANK_W-1:0] sel_bit;
    logic              per_bank;

    assign sel_bit  = BANK_W'(1) << i_item.irq_index[BIT_W-1:0];
    assign per_bank = i_item.irq_index[IDX_W-1];

    always_comb begin
        n_state = r_state;
        case (i_item.cmd)
            CMD_RAISE: begin
                n_state.sys_status = r_state.sys_status | i_item.sys_raise_bits;
                n_state.per_status = r_state.per_status | i_item.per_raise_bits;
            end
            CMD_UNMASK: begin
                if (per_bank) begin
                    n_state.per_mask = r_state.per_mask | sel_bit;
                end else begin
                    n_state.sys_mask = r_state.sys_mask | sel_bit;
                end
            end
            CMD_MASK: begin
                if (per_bank) begin
                    n_state.per_mask = r_state.per_mask & ~sel_bit;
                end else begin
                    n_state.sys_mask = r_state.sys_mask & ~sel_bit;
                end
            end
            CMD_ACK: begin
                if (per_bank) begin
                    n_state.per_status = r_state.per_status & ~sel_bit;
                end else begin
                    n_state.sys_status = r_state.sys_status & ~sel_bit;
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_we) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

// ===== hw/rtl/cimd_dispatch.sv =====
module cimd_dispatch
    import cimd_pkg::*;
(
    input  logic        i_is_dispatch,
    input  t_bank_state i_state,
    output t_out_item   o_result
);

    logic [BANK_W-1:0] sys_pend;
    logic [BANK_W-1:0] pend;
    logic              use_per;

    assign sys_pend = i_state.sys_status & i_state.sys_mask;
    assign use_per  = (sys_pend == CASCADE_MASK);
    assign pend     = use_per ? (i_state.per_status & i_state.per_mask) : sys_pend;

    always_comb begin
        o_result = '0;
        if (i_is_dispatch) begin
            if (pend == '0) begin
                o_result.spurious      = 1'b1;
                o_result.spurious_bank = use_per;
            end else begin
                o_result.irq_valid  = 1'b1;
                o_result.irq_number = {use_per, lowest_set(pend)};
            end
        end
    end

endmodule

// ===== hw/rtl/cascaded_interrupt_mask_dispatch_core.sv =====
// Two-bank cascaded interrupt controller core.
//
// Input channel (i_in_valid / i_in_data / o_in_ready) carries one command:
// raise, unmask, mask, acknowledge or dispatch. Every accepted command
// produces exactly one result on the output channel (o_out_valid /
// o_out_data / i_out_ready); only dispatch returns non-zero fields.
//
// The result of a command accepted at an edge is registered and presented
// from the next cycle. One command per cycle is sustained while each result
// is taken; the register update and the dispatch priority encode both settle
// within the cycle between the bank registers and the result register.
//
// o_in_ready is high whenever the result register is empty or being drained
// in the same cycle, so a stalled receiver holds the current result and
// blocks new commands only while that result is not taken.
//
// Synchronous reset clears status and mask of both banks and empties the
// result register.
module cascaded_interrupt_mask_dispatch_core
    import cimd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_ready
);

    t_bank_state state;
    t_out_item   result;
    logic        in_xfer;

    logic        r_out_valid;
    t_out_item   r_out_data;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    cimd_bank_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (in_xfer),
        .i_item  (i_in_data),
        .o_state (state)
    );

    cimd_dispatch u_disp (
        .i_is_dispatch (i_in_data.cmd == CMD_DISPATCH),
        .i_state       (state),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== hw/rtl/cimd_checker.sv =====
module cimd_checker
    import cimd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_ready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // every input transfer yields a result next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("missing result after input transfer");

    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.irq_valid && o_out_data.spurious))
        else $error("valid and spurious both set");

    a_clean_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.irq_valid |-> o_out_data.irq_number == '0)
        else $error("irq_number nonzero without irq_valid");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind cascaded_interrupt_mask_dispatch_core cimd_checker u_cimd_checker (.*);
